@@ rtl/dynamic_range_compressor_assert.svh @@
// Assertion macros shared by the compressor RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef DYNAMIC_RANGE_COMPRESSOR_ASSERT_SVH
`define DYNAMIC_RANGE_COMPRESSOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define DRC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("drc check failed");
`define DRC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("drc check failed");
`else
`define DRC_ASSERT_SAME(label, ante, cons)
`define DRC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ rtl/drc_pkg.sv @@
// Package for the dynamic range compressor: register map, config struct
// and fixed-point constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package drc_pkg;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_THRESHOLD = 3'd0,
    CFG_SLOPE     = 3'd1,
    CFG_ATTACK    = 3'd2,
    CFG_RELEASE   = 3'd3,
    CFG_MAKEUP    = 3'd4,
    CFG_CHANNELS  = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic signed [15:0] threshold_db;
    logic [15:0]        ratio_slope;
    logic [23:0]        attack_coeff;
    logic [23:0]        release_coeff;
    logic [12:0]        makeup_db;
    logic [1:0]         channel_count;
  } drc_cfg_t;

  localparam logic signed [15:0] THRESHOLD_RST = -16'sd4608;
  localparam logic [15:0]        SLOPE_RST     = 16'd43691;
  localparam logic [23:0]        ATTACK_RST    = 24'd16742302;
  localparam logic [23:0]        RELEASE_RST   = 24'd16773721;
  localparam logic [12:0]        MAKEUP_RST    = 13'd768;
  localparam logic [1:0]         CHANNELS_RST  = 2'd2;

  localparam logic [31:0]        DB_PER_LOG2_Q16 = 32'd394566;
  localparam logic [31:0]        LOG2_PER_DB_Q16 = 32'd10885;
  localparam logic signed [15:0] LEVEL_FLOOR_Q8  = -16'sd30720;
  localparam logic signed [23:0] ENV_RESET_Q16   = -24'sd6553600;
endpackage
`default_nettype wire

@@ rtl/drc_if.sv @@
// Channel interfaces of the compressor: input frames, results, config writes.
// Depends on drc_pkg for the config field widths.
`timescale 1ns / 1ps
`default_nettype none
interface drc_in_if #(parameter int SAMPLE_WIDTH = 24);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] left_sample;
  logic signed [SAMPLE_WIDTH-1:0] right_sample;
  logic                           end_of_block;
  modport source (output valid, left_sample, right_sample, end_of_block, input ready);
  modport sink   (input valid, left_sample, right_sample, end_of_block, output ready);
endinterface

interface drc_out_if #(parameter int SAMPLE_WIDTH = 24);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] left_out;
  logic signed [SAMPLE_WIDTH-1:0] right_out;
  logic signed [15:0]             applied_gain_db;
  logic                           end_of_block_out;
  modport source (output valid, left_out, right_out, applied_gain_db, end_of_block_out,
                  input ready);
  modport sink   (input valid, left_out, right_out, applied_gain_db, end_of_block_out,
                  output ready);
endinterface

interface drc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [drc_pkg::CFG_INDEX_W-1:0] index;
  logic [drc_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/drc_regs.sv @@
// Configuration register file of the compressor.
// Depends on drc_pkg and drc_cfg_if.
`timescale 1ns / 1ps
`default_nettype none
module drc_regs (
  input  wire logic        clk,
  input  wire logic        rst_n,
  drc_cfg_if.sink          cfg_ch,
  output drc_pkg::drc_cfg_t cfg
);
  import drc_pkg::*;

  drc_cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold_db  <= THRESHOLD_RST;
      cfg_r.ratio_slope   <= SLOPE_RST;
      cfg_r.attack_coeff  <= ATTACK_RST;
      cfg_r.release_coeff <= RELEASE_RST;
      cfg_r.makeup_db     <= MAKEUP_RST;
      cfg_r.channel_count <= CHANNELS_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_index_t'(cfg_ch.index))
        CFG_THRESHOLD: cfg_r.threshold_db  <= $signed(cfg_ch.data[15:0]);
        CFG_SLOPE:     cfg_r.ratio_slope   <= cfg_ch.data[15:0];
        CFG_ATTACK:    cfg_r.attack_coeff  <= cfg_ch.data[23:0];
        CFG_RELEASE:   cfg_r.release_coeff <= cfg_ch.data[23:0];
        CFG_MAKEUP:    cfg_r.makeup_db     <= cfg_ch.data[12:0];
        CFG_CHANNELS:  cfg_r.channel_count <= cfg_ch.data[1:0];
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ rtl/drc_mul.sv @@
// Shared signed multiplier with a registered product.
// No package dependencies.
`timescale 1ns / 1ps
`default_nettype none
module drc_mul #(
  parameter int AW = 25,
  parameter int BW = 32
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic signed [AW-1:0] a,
  input  wire logic signed [BW-1:0] b,
  output logic signed [AW+BW-1:0]   prod_r
);
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= a * b;
    end
  end
endmodule
`default_nettype wire

@@ rtl/dynamic_range_compressor.sv @@
// Feed-forward log-domain peak compressor, hard knee, one frame per transaction.
// Steps: normalise, log, dB, envelope, threshold, gain, power, left and right outputs;
// the normalising shifter moves one bit per cycle until the peak's leading one is on top.
// A frame is accepted only after the last result is taken; all products share one multiplier.
// Reset (synchronous, rst_n low) restores the register defaults and the -100 dB envelope.
`timescale 1ns / 1ps
`default_nettype none
`include "dynamic_range_compressor_assert.svh"
module dynamic_range_compressor #(
  parameter int SAMPLE_WIDTH   = 24,
  parameter int MAX_CHANNELS   = 2,
  parameter int LOG_TABLE_BITS = 8
) (
  input  wire logic clk,
  input  wire logic rst_n,
  drc_in_if.sink    in_ch,
  drc_out_if.source out_ch,
  drc_cfg_if.sink   cfg_ch
);
  import drc_pkg::*;

  localparam int SW       = SAMPLE_WIDTH;
  localparam int TB       = LOG_TABLE_BITS;
  localparam int TBL_SIZE = 1 << TB;
  localparam int CW       = $clog2(SW);
  // The multiplier's A side must hold a sample or a 25-bit dB difference.
  localparam int AW       = (SW > 25) ? SW : 25;
  localparam int BW       = 32;
  localparam int PW       = AW + BW;
  localparam logic signed [PW-1:0] SAT_HI = PW'((64'sd1 <<< (SW - 1)) - 64'sd1);
  localparam logic signed [PW-1:0] SAT_LO = -SAT_HI - PW'(1);

  typedef logic [15:0] log_tbl_t [TBL_SIZE];
  typedef logic [30:0] pow_tbl_t [TBL_SIZE];

  // Integer square root, used only while the tables are built.
  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] bt;
    v  = v_in;
    r  = 64'd0;
    bt = 64'd1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 64'd0) begin
      if (v >= r + bt) begin
        v = v - (r + bt);
        r = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    return r;
  endfunction

  // log2(1 + i/2^TB) in Q0.16 by repeated squaring of a Q1.30 value.
  function automatic log_tbl_t build_log();
    log_tbl_t    t;
    logic [63:0] x;
    logic [15:0] f;
    for (int i = 0; i < TBL_SIZE; i++) begin
      x = (64'(TBL_SIZE) + 64'(i)) << (30 - TB);
      f = 16'd0;
      for (int k = 15; k >= 0; k--) begin
        x = (x * x) >> 30;
        if (x >= (64'd2 << 30)) begin
          x    = x >> 1;
          f[k] = 1'b1;
        end
      end
      t[i] = f;
    end
    return t;
  endfunction

  // 2^(i/2^TB) in Q1.30 as a product of truncated roots of two.
  function automatic pow_tbl_t build_pow();
    pow_tbl_t    t;
    logic [63:0] root;
    logic [63:0] mant;
    for (int i = 0; i < TBL_SIZE; i++) begin
      root = 64'd2 << 30;
      mant = 64'd1 << 30;
      for (int k = 1; k <= TB; k++) begin
        root = isqrt64(root << 30);
        if (((i >> (TB - k)) & 1) != 0) mant = (mant * root) >> 30;
      end
      t[i] = mant[30:0];
    end
    return t;
  endfunction

  localparam log_tbl_t LOG_TBL = build_log();
  localparam pow_tbl_t POW_TBL = build_pow();

  typedef enum logic [3:0] {
    S_IDLE, S_NORM, S_LOG, S_DB, S_ENV, S_THR, S_GAIN, S_POW, S_OUTL, S_OUTR, S_DONE
  } state_t;

  drc_cfg_t cfg;

  state_t                state_r, state_nxt;
  logic signed [SW-1:0]  sl_r, sl_nxt, sr_r, sr_nxt;
  logic                  eob_r, eob_nxt, stereo_r, stereo_nxt, zero_r, zero_nxt;
  logic [SW-1:0]         norm_r, norm_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic signed [23:0]    env_r, env_nxt;
  logic                  red_r, red_nxt;
  logic signed [15:0]    gain_r, gain_nxt;
  logic signed [6:0]     n_r, n_nxt;
  logic [30:0]           mant_r, mant_nxt;
  logic signed [SW-1:0]  left_r, left_nxt, right_r, right_nxt;
  logic                  outv_r, outv_nxt;

  logic                  mul_en;
  logic signed [AW-1:0]  mul_a;
  logic signed [BW-1:0]  mul_b;
  logic signed [PW-1:0]  prod_r;

  // Combinational helpers for the individual steps.
  logic [SW-1:0]         mag_l, mag_r, peak;
  logic [SW+TB-1:0]      norm_ext;
  logic [TB-1:0]         log_idx, pow_idx;
  logic signed [CW:0]    neg_e;
  logic signed [CW+16:0] lvl_log2;
  logic signed [15:0]    db_q8;
  logic signed [23:0]    x16;
  logic signed [24:0]    env_diff, thr_diff;
  logic [24:0]           pole;
  logic signed [23:0]    thr16;
  logic signed [26:0]    total16;
  logic signed [18:0]    gain_wide;
  logic [5:0]            shamt;
  logic signed [PW-1:0]  shifted;
  logic signed [SW-1:0]  sat_val;

  drc_regs u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  drc_mul #(.AW(AW), .BW(BW)) u_mul (
    .clk    (clk),
    .en     (mul_en),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  assign in_ch.ready             = (state_r == S_IDLE);
  assign out_ch.valid            = outv_r;
  assign out_ch.left_out         = left_r;
  assign out_ch.right_out        = right_r;
  assign out_ch.applied_gain_db  = gain_r;
  assign out_ch.end_of_block_out = eob_r;

  always_comb begin
    // Magnitudes: the most negative sample maps onto 2^(SW-1), still in SW bits.
    mag_l = in_ch.left_sample[SW-1]  ? (~in_ch.left_sample + SW'(1))  : in_ch.left_sample;
    mag_r = in_ch.right_sample[SW-1] ? (~in_ch.right_sample + SW'(1)) : in_ch.right_sample;
    peak  = mag_l;
    if (MAX_CHANNELS >= 2 && cfg.channel_count[1] && mag_r > mag_l) peak = mag_r;

    // Fraction bits below the leading one index the log table; zeros fill short words.
    norm_ext = {norm_r, {TB{1'b0}}};
    log_idx  = norm_ext[SW+TB-2 -: TB];
    neg_e    = -$signed({1'b0, cnt_r});
    lvl_log2 = $signed({neg_e, LOG_TBL[log_idx]});

    db_q8 = $signed(prod_r[39:24]);
    if (zero_r || $signed(prod_r[PW-1:24]) < (PW-24)'(LEVEL_FLOOR_Q8)) db_q8 = LEVEL_FLOOR_Q8;
    x16      = {db_q8, 8'd0};
    env_diff = 25'(x16) - 25'(env_r);
    pole     = (x16 > env_r) ? (25'h1000000 - {1'b0, cfg.attack_coeff})
                             : (25'h1000000 - {1'b0, cfg.release_coeff});

    thr16    = {cfg.threshold_db, 8'd0};
    thr_diff = 25'(thr16) - 25'(env_r);

    total16 = (red_r ? $signed(prod_r[16 +: 27]) : 27'sd0) + $signed({6'd0, cfg.makeup_db, 8'd0});
    gain_wide = total16[26:8];

    pow_idx = prod_r[23 -: TB];

    // Scale back by 2^(30-n); the shift stays within 9 to 52 places.
    shamt   = 6'(7'sd30 - n_r);
    shifted = prod_r >>> shamt;
    if (shifted > SAT_HI)      sat_val = SAT_HI[SW-1:0];
    else if (shifted < SAT_LO) sat_val = SAT_LO[SW-1:0];
    else                       sat_val = shifted[SW-1:0];
  end

  always_comb begin
    state_nxt  = state_r;
    sl_nxt     = sl_r;
    sr_nxt     = sr_r;
    eob_nxt    = eob_r;
    stereo_nxt = stereo_r;
    zero_nxt   = zero_r;
    norm_nxt   = norm_r;
    cnt_nxt    = cnt_r;
    env_nxt    = env_r;
    red_nxt    = red_r;
    gain_nxt   = gain_r;
    n_nxt      = n_r;
    mant_nxt   = mant_r;
    left_nxt   = left_r;
    right_nxt  = right_r;
    outv_nxt   = outv_r;
    mul_en     = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          sl_nxt     = in_ch.left_sample;
          sr_nxt     = in_ch.right_sample;
          eob_nxt    = in_ch.end_of_block;
          stereo_nxt = (MAX_CHANNELS >= 2) && cfg.channel_count[1];
          zero_nxt   = (peak == '0);
          norm_nxt   = peak;
          cnt_nxt    = '0;
          state_nxt  = S_NORM;
        end
      end
      S_NORM: begin
        // One bit of normalisation per cycle until the leading one reaches the top.
        if (zero_r || norm_r[SW-1]) begin
          state_nxt = S_LOG;
        end else begin
          norm_nxt = norm_r << 1;
          cnt_nxt  = cnt_r + CW'(1);
        end
      end
      S_LOG: begin
        mul_en    = 1'b1;
        mul_a     = AW'(lvl_log2);
        mul_b     = $signed(DB_PER_LOG2_Q16);
        state_nxt = S_DB;
      end
      S_DB: begin
        mul_en    = 1'b1;
        mul_a     = AW'(env_diff);
        mul_b     = $signed(BW'(pole));
        state_nxt = S_ENV;
      end
      S_ENV: begin
        env_nxt   = env_r + prod_r[47:24];
        state_nxt = S_THR;
      end
      S_THR: begin
        red_nxt   = (env_r > thr16);
        mul_en    = 1'b1;
        mul_a     = AW'(thr_diff);
        mul_b     = $signed(BW'(cfg.ratio_slope));
        state_nxt = S_GAIN;
      end
      S_GAIN: begin
        if (gain_wide > 19'sd32767)       gain_nxt = 16'sd32767;
        else if (gain_wide < -19'sd32768) gain_nxt = -16'sd32768;
        else                              gain_nxt = gain_wide[15:0];
        mul_en    = 1'b1;
        mul_a     = AW'(gain_nxt);
        mul_b     = $signed(LOG2_PER_DB_Q16);
        state_nxt = S_POW;
      end
      S_POW: begin
        n_nxt     = $signed(prod_r[30:24]);
        mant_nxt  = POW_TBL[pow_idx];
        mul_en    = 1'b1;
        mul_a     = AW'(sl_r);
        mul_b     = $signed(BW'(mant_nxt));
        state_nxt = S_OUTL;
      end
      S_OUTL: begin
        left_nxt  = sat_val;
        mul_en    = 1'b1;
        mul_a     = AW'(sr_r);
        mul_b     = $signed(BW'(mant_r));
        state_nxt = S_OUTR;
      end
      S_OUTR: begin
        right_nxt = stereo_r ? sat_val : '0;
        outv_nxt  = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_ch.ready) begin
          outv_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      outv_r  <= 1'b0;
      env_r   <= ENV_RESET_Q16;
    end else begin
      state_r <= state_nxt;
      outv_r  <= outv_nxt;
      env_r   <= env_nxt;
    end
    sl_r     <= sl_nxt;
    sr_r     <= sr_nxt;
    eob_r    <= eob_nxt;
    stereo_r <= stereo_nxt;
    zero_r   <= zero_nxt;
    norm_r   <= norm_nxt;
    cnt_r    <= cnt_nxt;
    red_r    <= red_nxt;
    gain_r   <= gain_nxt;
    n_r      <= n_nxt;
    mant_r   <= mant_nxt;
    left_r   <= left_nxt;
    right_r  <= right_nxt;
  end

  // The frame in flight blocks new input until its result has been taken.
  `DRC_ASSERT_SAME(a_ready_excl, in_ch.ready, !out_ch.valid)
  `DRC_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready)
  `DRC_ASSERT_SAME(a_mono_zero, out_ch.valid && !stereo_r, out_ch.right_out == '0)
  `DRC_ASSERT_SAME(a_env_range, 1'b1,
                   env_r <= 24'sd0 && env_r >= $signed({LEVEL_FLOOR_Q8, 8'd0}))
endmodule
`default_nettype wire
